// ===== rtl/cv2d_pkg.sv =====
// ----------------------------------------------------------------------------
// cv2d_pkg
// Shared sizes, codes and types of the zero padded 2d convolution core.
// ----------------------------------------------------------------------------
package cv2d_pkg;

  // store geometry
  localparam int MAX_IMAGE_WIDTH  = 128;
  localparam int MAX_IMAGE_HEIGHT = 128;
  localparam int MAX_KERNEL_SIZE  = 15;

  localparam int IMG_DEPTH  = MAX_IMAGE_WIDTH * MAX_IMAGE_HEIGHT;
  localparam int KER_DEPTH  = MAX_KERNEL_SIZE * MAX_KERNEL_SIZE;
  localparam int IMG_ADDR_W = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
  localparam int KER_ADDR_W = (KER_DEPTH > 1) ? $clog2(KER_DEPTH) : 1;

  // field widths
  localparam int OP_W      = 2;
  localparam int COORD_W   = 7;
  localparam int VALUE_W   = 16;
  localparam int STATUS_W  = 2;
  localparam int IMG_DIM_W = 8;
  localparam int KDIM_W    = 4;
  localparam int POS_W     = COORD_W + 2;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = IMG_DIM_W;

  // arithmetic: Q8.8 pixel times Q2.14 coefficient, back to Q8.8
  localparam int COEF_FRAC  = 14;
  localparam int FRAC_DROP  = COEF_FRAC;
  localparam int PROD_W     = 2 * VALUE_W;
  localparam int ACC_W      = PROD_W + $clog2(KER_DEPTH + 1);

  // reset values of the registers
  localparam int RST_IMAGE_WIDTH   = 128;
  localparam int RST_IMAGE_HEIGHT  = 128;
  localparam int RST_KERNEL_WIDTH  = 3;
  localparam int RST_KERNEL_HEIGHT = 3;

  // request codes
  localparam logic [OP_W-1:0] OP_WR_KERNEL = 2'd0;
  localparam logic [OP_W-1:0] OP_WR_PIXEL  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY     = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_SAT   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_HEIGHT = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } seq_state_t;

  // store write request
  typedef struct packed {
    logic                      img_we;
    logic                      ker_we;
    logic [IMG_ADDR_W-1:0]     img_addr;
    logic [KER_ADDR_W-1:0]     ker_addr;
    logic signed [VALUE_W-1:0] data;
  } store_wr_t;

  // multiply-accumulate control
  typedef struct packed {
    logic clear;
    logic tap_ok;
  } mac_ctl_t;

  // register value forced into 1..maxv
  function automatic int clamp_dim(int v, int maxv);
    int r;
    r = v;
    if (v < 1) r = 1;
    else if (v > maxv) r = maxv;
    return r;
  endfunction

endpackage

// ===== rtl/cv2d_store.sv =====
// ----------------------------------------------------------------------------
// cv2d_store
// Image and kernel memories, one write port and one registered read each.
// ----------------------------------------------------------------------------
module cv2d_store (
  input  logic                                 clk,
  input  cv2d_pkg::store_wr_t                  wr,
  input  logic [cv2d_pkg::IMG_ADDR_W-1:0]      img_raddr,
  input  logic [cv2d_pkg::KER_ADDR_W-1:0]      ker_raddr,
  output logic signed [cv2d_pkg::VALUE_W-1:0]  img_rdata,
  output logic signed [cv2d_pkg::VALUE_W-1:0]  ker_rdata
);
  import cv2d_pkg::*;

  logic signed [VALUE_W-1:0] img_mem [IMG_DEPTH];
  logic signed [VALUE_W-1:0] ker_mem [KER_DEPTH];

  // image memory
  always_ff @(posedge clk) begin
    if (wr.img_we) begin
      img_mem[wr.img_addr] <= wr.data;
    end
    img_rdata <= img_mem[img_raddr];
  end

  // kernel memory
  always_ff @(posedge clk) begin
    if (wr.ker_we) begin
      ker_mem[wr.ker_addr] <= wr.data;
    end
    ker_rdata <= ker_mem[ker_raddr];
  end

endmodule

// ===== rtl/cv2d_mac.sv =====
// ----------------------------------------------------------------------------
// cv2d_mac
// Shared multiplier and accumulator with round half up and saturation.
// ----------------------------------------------------------------------------
module cv2d_mac (
  input  logic                                 clk,
  input  logic                                 rst,
  input  cv2d_pkg::mac_ctl_t                   ctl,
  input  logic signed [cv2d_pkg::VALUE_W-1:0]  pixel,
  input  logic signed [cv2d_pkg::VALUE_W-1:0]  coef,
  output logic signed [cv2d_pkg::VALUE_W-1:0]  q,
  output logic                                 sat
);
  import cv2d_pkg::*;

  localparam int QW = ACC_W + 1 - FRAC_DROP;
  localparam logic signed [ACC_W:0]  ROUND_BIAS = (ACC_W+1)'(1 << (FRAC_DROP - 1));
  localparam logic signed [QW-1:0]   Q_MAX = QW'((1 << (VALUE_W - 1)) - 1);
  localparam logic signed [QW-1:0]   Q_MIN = -QW'(1 << (VALUE_W - 1));

  logic signed [PROD_W-1:0] prod;
  logic                     prod_valid;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W:0]    biased;
  logic signed [QW-1:0]     q_wide;

  // product register
  always_ff @(posedge clk) begin
    prod <= pixel * coef;
  end

  // product valid flag
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctl.tap_ok;
    end
  end

  // accumulator
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // round to output fraction and clamp
  always_comb begin
    biased = (ACC_W+1)'(acc) + ROUND_BIAS;
    q_wide = QW'(biased >>> FRAC_DROP);
    sat    = 1'b0;
    q      = q_wide[VALUE_W-1:0];
    if (q_wide > Q_MAX) begin
      sat = 1'b1;
      q   = Q_MAX[VALUE_W-1:0];
    end else if (q_wide < Q_MIN) begin
      sat = 1'b1;
      q   = Q_MIN[VALUE_W-1:0];
    end
  end

endmodule

// ===== rtl/convolve_2d_zero_padded_core.sv =====
// ----------------------------------------------------------------------------
// convolve_2d_zero_padded_core
// Same size 2d convolution with zero padding, fixed point, one shared MAC.
// ----------------------------------------------------------------------------
// A kernel or pixel write request is stored as it is accepted. A compute
// request is accepted in the idle state, then runs one kernel tap per
// cycle through the single shared multiplier and the registered memory
// reads, a drain state for the read and multiply stages, and a final
// state that rounds and loads the result register. A compute request
// outside the configured image skips to the final state. The next request
// is accepted in the cycle after the final state; a finished result waits
// in the output register without holding up write requests. Both memories
// come up undefined and need no clearing after reset.
module convolve_2d_zero_padded_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [cv2d_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [cv2d_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [cv2d_pkg::OP_W-1:0]             op,
  input  logic [cv2d_pkg::COORD_W-1:0]          row,
  input  logic [cv2d_pkg::COORD_W-1:0]          col,
  input  logic signed [cv2d_pkg::VALUE_W-1:0]   value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [cv2d_pkg::VALUE_W-1:0]   result,
  output logic [cv2d_pkg::STATUS_W-1:0]         status
);
  import cv2d_pkg::*;

  logic [IMG_DIM_W-1:0] image_width;
  logic [IMG_DIM_W-1:0] image_height;
  logic [KDIM_W-1:0]    kernel_width;
  logic [KDIM_W-1:0]    kernel_height;

  seq_state_t state, state_next;

  logic                    in_acc;
  logic                    qry_acc;
  logic                    qry_out;
  logic                    issue;
  logic                    last_tap;
  logic                    tap_ok;
  logic                    out_free;
  logic                    out_load;
  logic [KDIM_W-1:0]       m_cnt;
  logic [KDIM_W-1:0]       n_cnt;
  logic signed [POS_W-1:0] r_pos;
  logic signed [POS_W-1:0] c_pos;
  logic signed [POS_W-1:0] c_start;
  logic [KER_ADDR_W-1:0]   kaddr;
  logic [KER_ADDR_W-1:0]   kbase;
  logic                    drain_cnt;
  logic                    err;
  logic                    tap_ok_d;

  store_wr_t             wr;
  mac_ctl_t              mac_ctl;
  logic [IMG_ADDR_W-1:0] img_raddr;
  logic signed [VALUE_W-1:0] img_rdata;
  logic signed [VALUE_W-1:0] ker_rdata;
  logic signed [VALUE_W-1:0] mac_q;
  logic                      mac_sat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= IMG_DIM_W'(clamp_dim(RST_IMAGE_WIDTH, MAX_IMAGE_WIDTH));
      image_height  <= IMG_DIM_W'(clamp_dim(RST_IMAGE_HEIGHT, MAX_IMAGE_HEIGHT));
      kernel_width  <= KDIM_W'(clamp_dim(RST_KERNEL_WIDTH, MAX_KERNEL_SIZE));
      kernel_height <= KDIM_W'(clamp_dim(RST_KERNEL_HEIGHT, MAX_KERNEL_SIZE));
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH: begin
          image_width <= IMG_DIM_W'(clamp_dim(int'(cfg_data[IMG_DIM_W-1:0]),
                                              MAX_IMAGE_WIDTH));
        end
        CFG_IMAGE_HEIGHT: begin
          image_height <= IMG_DIM_W'(clamp_dim(int'(cfg_data[IMG_DIM_W-1:0]),
                                               MAX_IMAGE_HEIGHT));
        end
        CFG_KERNEL_WIDTH: begin
          kernel_width <= KDIM_W'(clamp_dim(int'(cfg_data[KDIM_W-1:0]),
                                            MAX_KERNEL_SIZE));
        end
        CFG_KERNEL_HEIGHT: begin
          kernel_height <= KDIM_W'(clamp_dim(int'(cfg_data[KDIM_W-1:0]),
                                             MAX_KERNEL_SIZE));
        end
        default: begin
        end
      endcase
    end
  end

  // request decode
  assign in_acc  = in_valid && !in_stall;
  assign qry_acc = in_acc && (op == OP_QUERY);
  assign qry_out = (int'(row) >= int'(image_height)) || (int'(col) >= int'(image_width));

  // store writes, anything beyond the store is dropped
  always_comb begin
    wr.img_we   = in_acc && (op == OP_WR_PIXEL) &&
                  (int'(row) < MAX_IMAGE_HEIGHT) && (int'(col) < MAX_IMAGE_WIDTH);
    wr.ker_we   = in_acc && (op == OP_WR_KERNEL) &&
                  (int'(row) < MAX_KERNEL_SIZE) && (int'(col) < MAX_KERNEL_SIZE);
    wr.img_addr = IMG_ADDR_W'(int'(row) * MAX_IMAGE_WIDTH + int'(col));
    wr.ker_addr = KER_ADDR_W'(int'(row) * MAX_KERNEL_SIZE + int'(col));
    wr.data     = value;
  end

  // tap position checks and read address
  assign last_tap = (m_cnt == kernel_height - KDIM_W'(1)) &&
                    (n_cnt == kernel_width - KDIM_W'(1));
  assign tap_ok   = issue &&
                    !r_pos[POS_W-1] && (int'(r_pos[POS_W-2:0]) < int'(image_height)) &&
                    !c_pos[POS_W-1] && (int'(c_pos[POS_W-2:0]) < int'(image_width));
  assign img_raddr = IMG_ADDR_W'(int'(r_pos[POS_W-2:0]) * MAX_IMAGE_WIDTH +
                                 int'(c_pos[POS_W-2:0]));
  assign out_free = !out_valid || !out_stall;

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (qry_acc) begin
          state_next = qry_out ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        if (last_tap) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!drain_cnt) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall       = 1'b1;
    issue          = 1'b0;
    out_load       = 1'b0;
    unique case (state)
      ST_IDLE:  in_stall = 1'b0;
      ST_RUN:   issue    = 1'b1;
      ST_DRAIN: begin
      end
      ST_DONE:  out_load = out_free;
      default: begin
      end
    endcase
    mac_ctl.clear  = qry_acc;
    mac_ctl.tap_ok = tap_ok_d;
  end

  // tap walk: rows of the kernel outer, columns inner, image walked backward
  always_ff @(posedge clk) begin
    if (qry_acc) begin
      r_pos   <= $signed(POS_W'(row)) + $signed(POS_W'(kernel_height >> 1));
      c_pos   <= $signed(POS_W'(col)) + $signed(POS_W'(kernel_width >> 1));
      c_start <= $signed(POS_W'(col)) + $signed(POS_W'(kernel_width >> 1));
      m_cnt   <= '0;
      n_cnt   <= '0;
      kaddr   <= '0;
      kbase   <= '0;
      err     <= qry_out;
    end else if (issue) begin
      if (n_cnt == kernel_width - KDIM_W'(1)) begin
        n_cnt <= '0;
        m_cnt <= m_cnt + KDIM_W'(1);
        c_pos <= c_start;
        r_pos <= r_pos - POS_W'(1);
        kbase <= kbase + KER_ADDR_W'(MAX_KERNEL_SIZE);
        kaddr <= kbase + KER_ADDR_W'(MAX_KERNEL_SIZE);
      end else begin
        n_cnt <= n_cnt + KDIM_W'(1);
        c_pos <= c_pos - POS_W'(1);
        kaddr <= kaddr + KER_ADDR_W'(1);
      end
    end
  end

  // drain counter and read-stage tap flag
  always_ff @(posedge clk) begin
    if (rst) begin
      drain_cnt <= 1'b0;
      tap_ok_d  <= 1'b0;
    end else begin
      tap_ok_d <= tap_ok;
      if (issue && last_tap) begin
        drain_cnt <= 1'b1;
      end else if (state == ST_DRAIN) begin
        drain_cnt <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (err) begin
        result <= '0;
        status <= STATUS_RANGE;
      end else begin
        result <= mac_q;
        status <= mac_sat ? STATUS_SAT : STATUS_OK;
      end
    end
  end

  cv2d_store u_store (
    .clk       (clk),
    .wr        (wr),
    .img_raddr (img_raddr),
    .ker_raddr (kaddr),
    .img_rdata (img_rdata),
    .ker_rdata (ker_rdata)
  );

  cv2d_mac u_mac (
    .clk   (clk),
    .rst   (rst),
    .ctl   (mac_ctl),
    .pixel (img_rdata),
    .coef  (ker_rdata),
    .q     (mac_q),
    .sat   (mac_sat)
  );

endmodule
